// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: property does not hold");

// Check that a condition never occurs outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`endif

// ===== rtl/b2da_pkg.sv =====
`default_nettype none

package b2da_pkg;

  localparam int DIGIT_BITS     = 4;
  localparam int BITS_PER_STEP  = 4;
  localparam int CHAR_BITS      = 6;
  localparam int OUT_TDATA_BITS = 8;

  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO    = 6'd48;
  localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_BITS-1:0] DABBLE_ADJ   = 4'd3;

endpackage

`default_nettype wire

// ===== rtl/b2da_dabble.sv =====
`default_nettype none

module b2da_dabble #(
  parameter int NUM_DIGITS = 10
) (
  input  wire logic [NUM_DIGITS*b2da_pkg::DIGIT_BITS-1:0] bcd_in,
  input  wire logic [b2da_pkg::BITS_PER_STEP-1:0]         bits,
  output logic      [NUM_DIGITS*b2da_pkg::DIGIT_BITS-1:0] bcd_out
);

  localparam int BCD_W = NUM_DIGITS * b2da_pkg::DIGIT_BITS;

  logic [BCD_W-1:0] work;

  // correct each digit, then shift in one bit, most significant first
  always_comb begin
    work = bcd_in;
    for (int b = b2da_pkg::BITS_PER_STEP - 1; b >= 0; b--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (work[d*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] >= b2da_pkg::DABBLE_LIMIT) begin
          work[d*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] =
            work[d*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] + b2da_pkg::DABBLE_ADJ;
        end
      end
      work = {work[BCD_W-2:0], bits[b]};
    end
    bcd_out = work;
  end

endmodule

`default_nettype wire

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// Binary to decimal ASCII converter.
// Input stream (s_*): one unsigned integer per item in s_tdata. s_tready is
// high only while the block is idle; one item is converted at a time.
// Output stream (m_*): one ASCII digit per item, most significant first;
// m_tlast marks the least significant digit. Zero gives a single '0'.
// Conversion uses a shift-and-add-3 unit that takes four input bits per
// cycle. Leading zero digits are then dropped one per cycle, and digits
// leave one per cycle while m_tready is high. The default of 31 bits gives
// NUM_DIGITS = 10.
// When m_tready is low the current digit holds on m_tdata and m_tlast, and
// the block waits; no new item is taken until the last digit is delivered.
// Reset (rst, synchronous) returns the block to idle and drops any run in
// progress.
`default_nettype none

`include "assert_macros.svh"

module binary_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  // s_tdata: value [VALUE_BITS-1:0], zero padding above
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]         s_tdata,
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  // m_tdata: digit_char [5:0], zero padding above
  output logic      [b2da_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
  output logic                                         m_tlast
);

  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = NUM_DIGITS * b2da_pkg::DIGIT_BITS;
  localparam int STEPS      = (VALUE_BITS + b2da_pkg::BITS_PER_STEP - 1) / b2da_pkg::BITS_PER_STEP;
  localparam int PAD_BITS   = STEPS * b2da_pkg::BITS_PER_STEP;
  localparam int STEP_W     = $clog2(STEPS + 1);
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                              state;
  logic [PAD_BITS-1:0]                 val;
  logic [BCD_W-1:0]                    bcd;
  logic [BCD_W-1:0]                    bcd_next;
  logic [STEP_W-1:0]                   steps;
  logic [CNT_W-1:0]                    remaining;
  logic [b2da_pkg::DIGIT_BITS-1:0]     top_digit;
  logic [b2da_pkg::CHAR_BITS-1:0]      digit_char;

  b2da_dabble #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .bcd_in  (bcd),
    .bits    (val[PAD_BITS-1 -: b2da_pkg::BITS_PER_STEP]),
    .bcd_out (bcd_next)
  );

  assign top_digit  = bcd[BCD_W-1 -: b2da_pkg::DIGIT_BITS];
  assign digit_char = b2da_pkg::CHAR_ZERO + b2da_pkg::CHAR_BITS'(top_digit);

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tdata  = b2da_pkg::OUT_TDATA_BITS'(digit_char);
  assign m_tlast  = (remaining == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      steps     <= '0;
      remaining <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            val   <= PAD_BITS'(s_tdata[VALUE_BITS-1:0]);
            bcd   <= '0;
            steps <= STEP_W'(STEPS);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd   <= bcd_next;
          val   <= val << b2da_pkg::BITS_PER_STEP;
          steps <= steps - STEP_W'(1);
          if (steps == STEP_W'(1)) begin
            remaining <= CNT_W'(NUM_DIGITS);
            state     <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top_digit == '0 && remaining != CNT_W'(1)) begin
            bcd       <= bcd << b2da_pkg::DIGIT_BITS;
            remaining <= remaining - CNT_W'(1);
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            if (remaining == CNT_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              bcd       <= bcd << b2da_pkg::DIGIT_BITS;
              remaining <= remaining - CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overlap, clk, rst, s_tready && m_tvalid)
  `ASSERT_CLK(a_idle_after_last, clk, rst, m_tvalid && m_tready && m_tlast |=> s_tready)
  `ASSERT_CLK(a_accept_then_busy, clk, rst, s_tvalid && s_tready |=> !m_tvalid && !s_tready)
  `ASSERT_CLK(a_digit_range, clk, rst, m_tvalid |-> (m_tdata[5:0] >= 6'd48 && m_tdata[5:0] <= 6'd57))

endmodule

`default_nettype wire

// ===== tb/binary_to_decimal_ascii_top_tb.sv =====
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top_tb;

  localparam int VALUE_BITS   = 31;
  localparam int S_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int MAX_GAP      = 11;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 440;

  typedef struct packed {
    logic [b2da_pkg::CHAR_BITS-1:0] digit_char;
    logic                           last;
  } digit_item_t;

  logic                                  clk      = 1'b0;
  logic                                  rst      = 1'b1;
  logic                                  s_tvalid = 1'b0;
  logic                                  s_tready;
  logic [S_DATA_BITS-1:0]                s_tdata  = '0;
  logic                                  m_tvalid;
  logic                                  m_tready = 1'b0;
  logic [b2da_pkg::OUT_TDATA_BITS-1:0]   m_tdata;
  logic                                  m_tlast;

  digit_item_t expected_digits[$];
  int          error_count   = 0;
  int          idle_cycles   = 0;
  int          rx_hold_cycles = 0;
  bit          no_idle       = 1'b0;

  binary_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Split value into decimal digits, most significant first.
  task automatic predict_digits(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] rest;
    logic [3:0]            rev[20];
    int                    count;
    digit_item_t           item;
    rest  = value;
    count = 0;
    do begin
      rev[count] = 4'(rest % 10);
      rest       = VALUE_BITS'(rest / 10);
      count++;
    end while (rest != 0);
    for (int k = 0; k < count; k++) begin
      item.digit_char = b2da_pkg::CHAR_ZERO + b2da_pkg::CHAR_BITS'(rev[count - 1 - k]);
      item.last       = (k == count - 1);
      expected_digits.push_back(item);
    end
  endtask

  task automatic send_value(input logic [VALUE_BITS-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_BITS'(value);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_digits(value);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    int          ndigits;
    longint      lo;
    longint      hi;
    logic [31:0] raw;
    raw = $urandom();
    if ($urandom_range(0, 3) == 0) return raw[VALUE_BITS-1:0];
    ndigits = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < ndigits; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndigits == 1) lo = 0;
    if (hi > (longint'(1) << VALUE_BITS) - 1) hi = (longint'(1) << VALUE_BITS) - 1;
    return VALUE_BITS'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  task automatic test_directed_values();
    int values[$];
    values = '{0, 1, 9, 10, 11, 99, 100, 101, 999, 1000, 65535, 99999999, 100000000,
               999999999, 1000000000, 1073741823, 1073741824, 1431655765, 715827882,
               123456789, 2147483646, 2147483647};
    foreach (values[i]) send_value(VALUE_BITS'(values[i]));
    wait_drained();
  endtask

  task automatic test_random_values();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_value(random_value());
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_receiver_hold();
    rx_hold_cycles = LONG_HOLD;
    no_idle        = 1'b1;
    for (int i = 0; i < 20; i++) send_value(random_value());
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_sender_pause();
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 5; i++) send_value(random_value());
      wait_drained();
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_values();
    test_random_values();
    test_receiver_hold();
    test_sender_pause();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before each item.
  initial begin : digit_receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : digit_checker
    digit_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_digits.size() == 0) begin
        report_mismatch("digit with none pending", longint'(m_tdata), 0);
      end else begin
        want = expected_digits.pop_front();
        if (m_tdata[b2da_pkg::CHAR_BITS-1:0] !== want.digit_char)
          report_mismatch("digit_char", longint'(m_tdata[b2da_pkg::CHAR_BITS-1:0]),
                          longint'(want.digit_char));
        if (m_tlast !== want.last)
          report_mismatch("last", longint'(m_tlast), longint'(want.last));
      end
    end
  end

  always @(posedge clk) begin : stall_watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/b2da_pkg.sv
rtl/b2da_dabble.sv
rtl/binary_to_decimal_ascii_top.sv
tb/binary_to_decimal_ascii_top_tb.sv
